// ----- hdl/kvlp_pkg.sv -----
// Package for the key/value line parser: result and status codes, byte constants,
// and the command and status structs between the controller and the datapath.
// No dependencies.
package kvlp_pkg;

  localparam logic       KIND_BYTE = 1'b0;
  localparam logic       KIND_EOT  = 1'b1;

  localparam logic [1:0] RK_NAME  = 2'd0;
  localparam logic [1:0] RK_VALUE = 2'd1;
  localparam logic [1:0] RK_END   = 2'd2;
  localparam logic [1:0] RK_DONE  = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXP_NAME  = 2'd1;
  localparam logic [1:0] ST_EXP_EQ    = 2'd2;
  localparam logic [1:0] ST_WS_OVFL   = 2'd3;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_USCORE = 8'h5F;

  // What goes into the output register
  typedef enum logic [2:0] {
    SEL_NAME,
    SEL_VALUE,
    SEL_MEM,
    SEL_HOLD,
    SEL_END,
    SEL_DONE
  } out_sel_t;

  typedef struct packed {
    logic       take;
    logic       line_inc;
    logic       parse_clear;
    logic       fail_set;
    logic [1:0] fail_code;
    logic       pend_push;
    logic       pend_clear;
    logic       hold_load;
    logic       flush_step;
    logic       out_load;
    out_sel_t   out_sel;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic kind;
    logic is_lf;
    logic is_ws;
    logic is_hash;
    logic is_eq;
    logic is_name_start;
    logic is_name_char;
    logic deliver;
    logic pend_full;
    logic pend_empty;
    logic flush_last;
    logic out_free;
  } stat_t;

endpackage

// ----- hdl/kvlp_in_if.sv -----
// Input channel of the key/value line parser: valid/ready plus one text item.
// No dependencies.
interface kvlp_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink (input valid, input kind, input text_byte, output ready);
endinterface

// ----- hdl/kvlp_out_if.sv -----
// Result channel of the key/value line parser: valid/ready plus one result item.
// No dependencies.
interface kvlp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  out_byte;
  logic [1:0]  status;
  logic [15:0] bad_line;
  logic        last_of_run;

  modport source (output valid, output result_kind, output out_byte, output status,
                  output bad_line, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input out_byte, input status,
                input bad_line, input last_of_run, output ready);
endinterface

// ----- hdl/kvlp_datapath.sv -----
// Datapath of the key/value line parser: byte classes, line counter, error record,
// trailing-whitespace buffer, output register. Depends on kvlp_pkg and the channel
// interfaces.
module kvlp_datapath #(
  parameter int WS_DEPTH  = 32,
  parameter int LINE_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  kvlp_in_if.sink          in_ch,
  kvlp_out_if.source       out_ch,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  kvlp_pkg::cmd_t   cmd,
  output kvlp_pkg::stat_t  stat
);

  localparam int CW = $clog2(WS_DEPTH + 1);
  localparam int IW = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;

  logic                 deliver;
  logic [LINE_BITS-1:0] line_count;
  logic [LINE_BITS-1:0] line_now;
  logic [1:0]           fail_code;
  logic [LINE_BITS-1:0] fail_line;
  logic [CW-1:0]        pend_count;
  logic [CW-1:0]        rd_ptr;
  logic [CW-1:0]        rd_ptr_inc;
  logic [IW-1:0]        rd_addr;
  logic [7:0]           rd_data;
  logic [7:0]           hold_byte;
  logic [7:0]           mem [WS_DEPTH];
  logic [7:0]           b;
  logic                 is_alpha;
  logic                 is_digit;

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_byte;
  logic [1:0]  out_status;
  logic [15:0] out_line;
  logic        out_last;
  logic [1:0]  kind_next;
  logic [7:0]  byte_next;
  logic [1:0]  status_next;
  logic [15:0] line_next;

  // Byte classes
  assign b        = in_ch.text_byte;
  assign is_alpha = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
  assign is_digit = (b >= 8'h30 && b <= 8'h39);

  always_comb begin
    stat               = '0;
    stat.in_valid      = in_ch.valid;
    stat.kind          = in_ch.kind;
    stat.is_lf         = (b == kvlp_pkg::CH_LF);
    stat.is_ws         = (b == kvlp_pkg::CH_SPACE) ||
                         (b >= kvlp_pkg::CH_TAB && b <= kvlp_pkg::CH_CR);
    stat.is_hash       = (b == kvlp_pkg::CH_HASH);
    stat.is_eq         = (b == kvlp_pkg::CH_EQ);
    stat.is_name_start = is_alpha || (b == kvlp_pkg::CH_USCORE);
    stat.is_name_char  = is_alpha || is_digit || (b == kvlp_pkg::CH_USCORE);
    stat.deliver       = deliver;
    stat.pend_full     = (pend_count >= CW'(WS_DEPTH));
    stat.pend_empty    = (pend_count == '0);
    stat.flush_last    = (rd_ptr == pend_count);
    stat.out_free      = !out_valid || out_ch.ready;
  end

  assign in_ch.ready = cmd.take;

  // Line count after this item's increment, saturating
  always_comb begin
    line_now = line_count;
    if (cmd.line_inc && (line_count != {LINE_BITS{1'b1}})) begin
      line_now = line_count + LINE_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      deliver    <= 1'b1;
      line_count <= '0;
      fail_code  <= kvlp_pkg::ST_OK;
      fail_line  <= '0;
      pend_count <= '0;
      rd_ptr     <= '0;
    end else begin
      if (cfg_wr_en) begin
        deliver <= cfg_wr_data;
      end
      if (cmd.parse_clear) begin
        line_count <= '0;
        fail_code  <= kvlp_pkg::ST_OK;
        fail_line  <= '0;
      end else begin
        line_count <= line_now;
        if (cmd.fail_set) begin
          fail_code <= cmd.fail_code;
          fail_line <= line_now;
        end
      end
      if (cmd.pend_clear) begin
        pend_count <= '0;
        rd_ptr     <= '0;
      end else begin
        if (cmd.pend_push) begin
          pend_count <= pend_count + CW'(1);
        end
        if (cmd.flush_step) begin
          rd_ptr <= rd_ptr_inc;
        end
      end
    end
  end

  // Read address runs one ahead of the byte being sent so that the registered
  // read data is ready when the output register takes it
  assign rd_ptr_inc = rd_ptr + CW'(1);

  always_comb begin
    if (cmd.flush_step) begin
      rd_addr = (rd_ptr_inc == pend_count) ? '0 : rd_ptr_inc[IW-1:0];
    end else begin
      rd_addr = (rd_ptr == pend_count) ? '0 : rd_ptr[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_push) begin
      mem[pend_count[IW-1:0]] <= b;
    end
    rd_data <= mem[rd_addr];
    if (cmd.hold_load) begin
      hold_byte <= b;
    end
  end

  // Output register payload
  always_comb begin
    kind_next   = kvlp_pkg::RK_DONE;
    byte_next   = '0;
    status_next = kvlp_pkg::ST_OK;
    line_next   = '0;
    unique case (cmd.out_sel)
      kvlp_pkg::SEL_NAME: begin
        kind_next = kvlp_pkg::RK_NAME;
        byte_next = b;
      end
      kvlp_pkg::SEL_VALUE: begin
        kind_next = kvlp_pkg::RK_VALUE;
        byte_next = b;
      end
      kvlp_pkg::SEL_MEM: begin
        kind_next = kvlp_pkg::RK_VALUE;
        byte_next = rd_data;
      end
      kvlp_pkg::SEL_HOLD: begin
        kind_next = kvlp_pkg::RK_VALUE;
        byte_next = hold_byte;
      end
      kvlp_pkg::SEL_END: begin
        kind_next = kvlp_pkg::RK_END;
      end
      kvlp_pkg::SEL_DONE: begin
        kind_next   = kvlp_pkg::RK_DONE;
        status_next = cmd.fail_set ? cmd.fail_code : fail_code;
        line_next   = cmd.fail_set ? 16'(line_count) : 16'(fail_line);
      end
      default: begin
        kind_next = kvlp_pkg::RK_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_kind   <= kind_next;
      out_byte   <= byte_next;
      out_status <= status_next;
      out_line   <= line_next;
      out_last   <= cmd.out_last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.result_kind = out_kind;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.status      = out_status;
  assign out_ch.bad_line    = out_line;
  assign out_ch.last_of_run = out_last;

endmodule

// ----- hdl/kvlp_ctrl.sv -----
// Controller of the key/value line parser: line syntax state machine and the
// sequencing of whitespace flushes and end-of-text results. Depends on kvlp_pkg.
module kvlp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  kvlp_pkg::stat_t  stat,
  output kvlp_pkg::cmd_t   cmd
);

  typedef enum logic [1:0] {
    S_RUN,
    S_FLUSH,
    S_DONE
  } seq_t;

  typedef enum logic [2:0] {
    PH_START,
    PH_LEAD,
    PH_COMMENT,
    PH_NAME,
    PH_PREEQ,
    PH_PREVAL,
    PH_VALUE,
    PH_FAIL
  } phase_t;

  seq_t   st;
  seq_t   st_next;
  phase_t phase;
  phase_t phase_next;
  phase_t eff;
  logic   fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_RUN;
      phase <= PH_START;
    end else begin
      st    <= st_next;
      phase <= phase_next;
    end
  end

  assign fire = (st == S_RUN) && stat.in_valid && stat.out_free;
  assign eff  = (phase == PH_START) ? PH_LEAD : phase;

  always_comb begin
    cmd         = '0;
    cmd.out_sel = kvlp_pkg::SEL_DONE;
    cmd.take    = (st == S_RUN) && stat.out_free;
    st_next     = st;
    phase_next  = phase;
    unique case (st)
      S_RUN: begin
        if (fire && stat.kind == kvlp_pkg::KIND_EOT) begin
          cmd.parse_clear = 1'b1;
          cmd.pend_clear  = 1'b1;
          cmd.out_load    = 1'b1;
          phase_next      = PH_START;
          if (phase == PH_NAME || phase == PH_PREEQ) begin
            cmd.fail_set  = 1'b1;
            cmd.fail_code = kvlp_pkg::ST_EXP_EQ;
            cmd.out_last  = 1'b1;
          end else if ((phase == PH_PREVAL || phase == PH_VALUE) && stat.deliver) begin
            cmd.out_sel = kvlp_pkg::SEL_END;
            st_next     = S_DONE;
          end else begin
            cmd.out_last = 1'b1;
          end
        end else if (fire) begin
          cmd.line_inc = (phase == PH_START);
          phase_next   = eff;
          cmd.out_last = 1'b1;
          unique case (eff)
            PH_LEAD: begin
              if (stat.is_lf) begin
                phase_next = PH_START;
              end else if (stat.is_ws) begin
                phase_next = PH_LEAD;
              end else if (stat.is_hash) begin
                phase_next = PH_COMMENT;
              end else if (stat.is_name_start) begin
                cmd.out_load = stat.deliver;
                cmd.out_sel  = kvlp_pkg::SEL_NAME;
                phase_next   = PH_NAME;
              end else begin
                cmd.fail_set  = 1'b1;
                cmd.fail_code = kvlp_pkg::ST_EXP_NAME;
                phase_next    = PH_FAIL;
              end
            end
            PH_COMMENT: begin
              if (stat.is_lf) begin
                phase_next = PH_START;
              end
            end
            PH_NAME: begin
              if (stat.is_name_char) begin
                cmd.out_load = stat.deliver;
                cmd.out_sel  = kvlp_pkg::SEL_NAME;
              end else if (stat.is_eq) begin
                phase_next = PH_PREVAL;
              end else if (stat.is_ws && !stat.is_lf) begin
                phase_next = PH_PREEQ;
              end else begin
                cmd.fail_set  = 1'b1;
                cmd.fail_code = kvlp_pkg::ST_EXP_EQ;
                phase_next    = PH_FAIL;
              end
            end
            PH_PREEQ: begin
              if (stat.is_eq) begin
                phase_next = PH_PREVAL;
              end else if (stat.is_lf || !stat.is_ws) begin
                cmd.fail_set  = 1'b1;
                cmd.fail_code = kvlp_pkg::ST_EXP_EQ;
                phase_next    = PH_FAIL;
              end
            end
            PH_PREVAL: begin
              if (stat.is_lf) begin
                cmd.out_load = stat.deliver;
                cmd.out_sel  = kvlp_pkg::SEL_END;
                phase_next   = PH_START;
              end else if (!stat.is_ws) begin
                cmd.out_load   = stat.deliver;
                cmd.out_sel    = kvlp_pkg::SEL_VALUE;
                cmd.pend_clear = 1'b1;
                phase_next     = PH_VALUE;
              end
            end
            PH_VALUE: begin
              if (stat.is_lf) begin
                cmd.out_load   = stat.deliver;
                cmd.out_sel    = kvlp_pkg::SEL_END;
                cmd.pend_clear = 1'b1;
                phase_next     = PH_START;
              end else if (stat.is_ws) begin
                if (stat.pend_full) begin
                  cmd.fail_set  = 1'b1;
                  cmd.fail_code = kvlp_pkg::ST_WS_OVFL;
                  phase_next    = PH_FAIL;
                end else begin
                  cmd.pend_push = 1'b1;
                end
              end else if (stat.deliver && !stat.pend_empty) begin
                // hold the byte; send the buffered whitespace first
                cmd.hold_load = 1'b1;
                st_next       = S_FLUSH;
              end else begin
                cmd.out_load   = stat.deliver;
                cmd.out_sel    = kvlp_pkg::SEL_VALUE;
                cmd.pend_clear = 1'b1;
              end
            end
            PH_START, PH_FAIL: begin
              phase_next = phase;
            end
            default: begin
              phase_next = phase;
            end
          endcase
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (stat.flush_last) begin
            cmd.out_sel    = kvlp_pkg::SEL_HOLD;
            cmd.out_last   = 1'b1;
            cmd.pend_clear = 1'b1;
            st_next        = S_RUN;
          end else begin
            cmd.out_sel    = kvlp_pkg::SEL_MEM;
            cmd.flush_step = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = kvlp_pkg::SEL_DONE;
          cmd.out_last = 1'b1;
          st_next      = S_RUN;
        end
      end
      default: begin
        st_next = S_RUN;
      end
    endcase
  end

endmodule

// ----- hdl/key_value_line_parser.sv -----
// Key/value line parser. A result that an accepted item causes directly is loaded
// into the output register as the item is accepted. One text byte per cycle while
// the output register is free and no flush or end result is due; held whitespace
// goes out one result per free cycle before its value byte; end of text closing a
// pair gives a pair end, then done. Reset (rst, synchronous, active high) clears the
// parse state, sets deliver to 1; whitespace buffer is left and needs no clearing.
module key_value_line_parser #(
  parameter int WS_DEPTH  = 32,
  parameter int LINE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  kvlp_in_if.sink     in_ch,
  kvlp_out_if.source  out_ch,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  // Commands from the controller, status back from the datapath
  kvlp_pkg::cmd_t  cmd;
  kvlp_pkg::stat_t stat;

  // Syntax state machine; also sequences the whitespace flush, in which the buffered
  // bytes go one per cycle while the output is free, ahead of the held value byte
  kvlp_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // Byte classes, line counter, error record, whitespace buffer and the output
  // register that parts the two channels
  kvlp_datapath #(
    .WS_DEPTH  (WS_DEPTH),
    .LINE_BITS (LINE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat)
  );

`ifndef NO_ASSERTIONS
  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("output register loaded while a result waits");

  // Never push into a full whitespace buffer
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cmd.pend_push |-> !stat.pend_full)
    else $error("whitespace buffer pushed while full");

  // Flush never steps past the buffered count
  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.flush_step |-> !stat.flush_last)
    else $error("flush stepped beyond held whitespace");

  // End of text always yields a result in the next cycle
  a_eot_result: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready && in_ch.kind == kvlp_pkg::KIND_EOT) |=> out_ch.valid)
    else $error("end of text without a result");
`endif

endmodule

// ----- test/key_value_line_parser_tb.sv -----
// Testbench for key_value_line_parser: directed and random texts, a delivery switch,
// and a cycle-free predictor that checks every result field by field.
// Depends on kvlp_pkg, kvlp_in_if, kvlp_out_if and the parser RTL.
module key_value_line_parser_tb;

  localparam int          WS_DEPTH     = 32;
  localparam logic [15:0] LINE_MAX     = 16'hFFFF;
  localparam logic [7:0]  CH_VT        = 8'h0B;
  localparam logic [7:0]  CH_FF        = 8'h0C;
  localparam int          RANDOM_ITEMS = 160;

  typedef enum logic [2:0] {
    PS_START, PS_LEAD, PS_COMMENT, PS_NAME, PS_PRE_EQ, PS_PRE_VALUE, PS_VALUE, PS_FAILED
  } parse_state_t;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [1:0]  status;
    logic [15:0] line;
    logic        last;
  } parse_result_t;

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic cfg_wr_data;

  kvlp_in_if  text_if();
  kvlp_out_if result_if();

  key_value_line_parser dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (text_if),
    .out_ch     (result_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Predicted parser state and configuration
  logic         model_deliver;
  parse_state_t model_state;
  logic [15:0]  model_lines;
  logic [7:0]   held_ws[$];
  logic [1:0]   model_fail_code;
  logic [15:0]  model_fail_line;

  parse_result_t awaited[$];      // results predicted but not yet seen
  int            run_results;     // results caused by the item being predicted
  int            mismatch_count = 0;
  int            items_sent = 0;
  bit            steady = 1'b0;   // no gaps and no stalls while set
  logic [7:0]    text_buf[$];     // random text being built

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Character classes
  // ---------------------------------------------------------------------------
  function automatic bit is_space(logic [7:0] c);
    return c == kvlp_pkg::CH_SPACE || (c >= kvlp_pkg::CH_TAB && c <= kvlp_pkg::CH_CR);
  endfunction

  function automatic bit is_name_start(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == kvlp_pkg::CH_USCORE;
  endfunction

  function automatic bit is_name_char(logic [7:0] c);
    return is_name_start(c) || (c >= "0" && c <= "9");
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void emit(logic [1:0] kind, logic [7:0] data, logic [1:0] st,
                               logic [15:0] line);
    parse_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = st;
    r.line   = line;
    r.last   = 1'b0;
    awaited.push_back(r);
    run_results++;
  endfunction

  // Name and value bytes and pair ends only appear with delivery switched on
  function automatic void emit_pair(logic [1:0] kind, logic [7:0] data);
    if (model_deliver)
      emit(kind, data, kvlp_pkg::ST_OK, 16'd0);
  endfunction

  function automatic void raise_error(logic [1:0] code);
    model_fail_code = code;
    model_fail_line = model_lines;
    model_state     = PS_FAILED;
  endfunction

  function automatic void restart_parse();
    model_state     = PS_START;
    model_lines     = 16'd0;
    model_fail_code = kvlp_pkg::ST_OK;
    model_fail_line = 16'd0;
    held_ws.delete();
  endfunction

  // Advance the predicted state by one accepted item and queue its results
  function automatic void parse_text_item(logic kind, logic [7:0] c);
    run_results = 0;
    if (kind == kvlp_pkg::KIND_EOT) begin
      if (model_state == PS_NAME || model_state == PS_PRE_EQ)
        raise_error(kvlp_pkg::ST_EXP_EQ);
      else if (model_state == PS_PRE_VALUE || model_state == PS_VALUE)
        emit_pair(kvlp_pkg::RK_END, 8'd0);
      if (model_state == PS_FAILED)
        emit(kvlp_pkg::RK_DONE, 8'd0, model_fail_code, model_fail_line);
      else
        emit(kvlp_pkg::RK_DONE, 8'd0, kvlp_pkg::ST_OK, 16'd0);
      restart_parse();
    end else begin
      // A line counts once its first byte arrives; the count saturates
      if (model_state == PS_START) begin
        if (model_lines != LINE_MAX)
          model_lines++;
        model_state = PS_LEAD;
      end
      case (model_state)
        PS_LEAD: begin
          if (c == kvlp_pkg::CH_LF)
            model_state = PS_START;
          else if (c == kvlp_pkg::CH_HASH)
            model_state = PS_COMMENT;
          else if (is_name_start(c)) begin
            emit_pair(kvlp_pkg::RK_NAME, c);
            model_state = PS_NAME;
          end else if (!is_space(c))
            raise_error(kvlp_pkg::ST_EXP_NAME);
        end
        PS_COMMENT: begin
          if (c == kvlp_pkg::CH_LF)
            model_state = PS_START;
        end
        PS_NAME: begin
          if (is_name_char(c))
            emit_pair(kvlp_pkg::RK_NAME, c);
          else if (c == kvlp_pkg::CH_EQ)
            model_state = PS_PRE_VALUE;
          else if (c != kvlp_pkg::CH_LF && is_space(c))
            model_state = PS_PRE_EQ;
          else
            raise_error(kvlp_pkg::ST_EXP_EQ);
        end
        PS_PRE_EQ: begin
          if (c == kvlp_pkg::CH_EQ)
            model_state = PS_PRE_VALUE;
          else if (c == kvlp_pkg::CH_LF || !is_space(c))
            raise_error(kvlp_pkg::ST_EXP_EQ);
        end
        PS_PRE_VALUE: begin
          if (c == kvlp_pkg::CH_LF) begin
            emit_pair(kvlp_pkg::RK_END, 8'd0);
            model_state = PS_START;
          end else if (!is_space(c)) begin
            emit_pair(kvlp_pkg::RK_VALUE, c);
            held_ws.delete();
            model_state = PS_VALUE;
          end
        end
        PS_VALUE: begin
          if (c == kvlp_pkg::CH_LF) begin
            // trailing whitespace is dropped with the line end
            emit_pair(kvlp_pkg::RK_END, 8'd0);
            held_ws.delete();
            model_state = PS_START;
          end else if (is_space(c)) begin
            if (held_ws.size() >= WS_DEPTH)
              raise_error(kvlp_pkg::ST_WS_OVFL);
            else
              held_ws.push_back(c);
          end else begin
            // interior whitespace is kept: flush it ahead of the value byte
            foreach (held_ws[i])
              emit_pair(kvlp_pkg::RK_VALUE, held_ws[i]);
            held_ws.delete();
            emit_pair(kvlp_pkg::RK_VALUE, c);
          end
        end
        default: ;
      endcase
    end
    if (run_results > 0)
      awaited[awaited.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Offer one item at a falling edge and hold it until a transfer takes it
  task automatic send_item(logic kind, logic [7:0] data);
    int gap;
    gap = steady ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      text_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_if.kind      = kind;
    text_if.text_byte = data;
    text_if.valid     = 1'b1;
    do @(posedge clk); while (!text_if.ready);
    parse_text_item(kind, data);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++)
      send_item(kvlp_pkg::KIND_BYTE, s[i]);
  endtask

  task automatic end_text();
    send_item(kvlp_pkg::KIND_EOT, 8'($urandom_range(0, 255)));
  endtask

  task automatic idle_input();
    @(negedge clk);
    text_if.valid = 1'b0;
  endtask

  // Write the delivery switch once all results are in and the parser has settled
  task automatic set_delivery(logic enable);
    idle_input();
    while (awaited.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = enable;
    @(negedge clk);
    cfg_wr_en     = 1'b0;
    model_deliver = enable;
  endtask

  // Result side: random stalls, mostly short, a few long
  initial begin : result_stall
    int hold_left;
    hold_left       = 0;
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (steady)
        result_if.ready = 1'b1;
      else if (hold_left > 0)
        hold_left--;
      else if ($urandom_range(0, 3) != 0) begin
        result_if.ready = 1'b1;
        hold_left       = $urandom_range(0, 10);
      end else begin
        result_if.ready = 1'b0;
        hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                : $urandom_range(0, 2);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checking: compare each transfer with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (awaited.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result kind %0d byte %02h status %0d line %0d last %0b",
                   $time, result_if.result_kind, result_if.out_byte, result_if.status,
                   result_if.bad_line, result_if.last_of_run);
      end else begin
        want = awaited.pop_front();
        if (result_if.result_kind !== want.kind || result_if.out_byte !== want.data ||
            result_if.status !== want.status || result_if.bad_line !== want.line ||
            result_if.last_of_run !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: mismatch: expected kind %0d byte %02h st %0d line %0d last %0b",
                     $time, want.kind, want.data, want.status, want.line, want.last);
            $display("  got kind %0d byte %02h st %0d line %0d last %0b",
                     result_if.result_kind, result_if.out_byte, result_if.status,
                     result_if.bad_line, result_if.last_of_run);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random text generation
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_space();
    case ($urandom_range(0, 7))
      0:       return kvlp_pkg::CH_TAB;
      1:       return CH_VT;
      2:       return CH_FF;
      3:       return kvlp_pkg::CH_CR;
      default: return kvlp_pkg::CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] pick_name_start();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26)
      return 8'("A" + r);
    if (r < 52)
      return 8'("a" + r - 26);
    return kvlp_pkg::CH_USCORE;
  endfunction

  function automatic logic [7:0] pick_name_char();
    if ($urandom_range(0, 5) == 0)
      return 8'("0" + $urandom_range(0, 9));
    return pick_name_start();
  endfunction

  function automatic logic [7:0] pick_value_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (is_space(c));
    return c;
  endfunction

  function automatic void add_spaces(int n);
    repeat (n) text_buf.push_back(pick_space());
  endfunction

  function automatic void add_name();
    text_buf.push_back(pick_name_start());
    repeat ($urandom_range(0, 6)) text_buf.push_back(pick_name_char());
  endfunction

  // Whitespace runs: mostly short, now and then exactly the buffer depth or one over
  function automatic int pick_run(int short_max);
    int r;
    r = $urandom_range(0, 99);
    if (r < 92)
      return $urandom_range(short_max == 3 ? 1 : 0, short_max);
    if (r < 97)
      return WS_DEPTH;
    return WS_DEPTH + 1;
  endfunction

  function automatic void add_pair_line();
    int pieces;
    add_spaces($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    add_name();
    add_spaces($urandom_range(0, 2));
    text_buf.push_back(kvlp_pkg::CH_EQ);
    add_spaces($urandom_range(0, 2));
    pieces = $urandom_range(0, 3);
    for (int p = 0; p < pieces; p++) begin
      if (p > 0)
        add_spaces(pick_run(3));
      repeat ($urandom_range(1, 4)) text_buf.push_back(pick_value_byte());
    end
    if (pieces > 0)
      add_spaces(pick_run(2));
    text_buf.push_back(kvlp_pkg::CH_LF);
  endfunction

  function automatic void add_line();
    int         r;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 60)
      add_pair_line();
    else if (r < 70) begin
      add_spaces($urandom_range(0, 2));
      text_buf.push_back(kvlp_pkg::CH_LF);
    end else if (r < 78) begin
      add_spaces($urandom_range(0, 2));
      text_buf.push_back(kvlp_pkg::CH_HASH);
      repeat ($urandom_range(0, 6)) begin
        do c = 8'($urandom_range(0, 255)); while (c == kvlp_pkg::CH_LF);
        text_buf.push_back(c);
      end
      text_buf.push_back(kvlp_pkg::CH_LF);
    end else if (r < 90) begin
      // name cut short by a line end or followed by a byte that cannot follow it
      add_spaces($urandom_range(0, 1));
      add_name();
      if ($urandom_range(0, 2) == 0)
        add_spaces($urandom_range(1, 2));
      if ($urandom_range(0, 1) == 0) begin
        do c = 8'($urandom_range(0, 255));
        while (is_name_char(c) || is_space(c) || c == kvlp_pkg::CH_EQ);
        text_buf.push_back(c);
      end
      text_buf.push_back(kvlp_pkg::CH_LF);
    end else begin
      repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      text_buf.push_back(kvlp_pkg::CH_LF);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_empty_text();
    end_text();
  endtask

  // Leading whitespace, a comment, a name opening with '_', spaces around '=',
  // interior and trailing whitespace, an empty value and end of text in a value
  task automatic test_well_formed_pairs();
    send_text("  #c\n_k9 = a b\t \r\nx=\nv=");
    send_item(kvlp_pkg::KIND_BYTE, 8'h00);
    send_item(kvlp_pkg::KIND_BYTE, 8'hFF);
    end_text();
  endtask

  task automatic test_syntax_errors();
    send_text("9=x\n");   // no name: the rest of the text is ignored
    end_text();
    send_text("\nab\n");  // line end inside a name, on line 2
    end_text();
    send_text("a-");      // bad byte after a name
    end_text();
    send_text("a b");     // bad byte where '=' belongs
    end_text();
    send_text("k=v\na "); // end of text before '='
    end_text();
  endtask

  // Fill the whitespace buffer exactly, flush it, then overflow it on line 2
  task automatic test_ws_overflow();
    send_text("w=v");
    repeat (WS_DEPTH) send_item(kvlp_pkg::KIND_BYTE, kvlp_pkg::CH_SPACE);
    send_text("x\nw=v");
    repeat (WS_DEPTH + 1) send_item(kvlp_pkg::KIND_BYTE, kvlp_pkg::CH_TAB);
    send_text("y\n");
    end_text();
  endtask

  // Syntax is still checked with delivery off, overflow included
  task automatic test_without_delivery();
    set_delivery(1'b0);
    send_text("a = b c \n#x\n");
    end_text();
    send_text("q=1");
    repeat (WS_DEPTH + 1) send_item(kvlp_pkg::KIND_BYTE, kvlp_pkg::CH_SPACE);
    end_text();
    set_delivery(1'b1);
  endtask

  task automatic test_random_texts();
    int start_count;
    start_count = items_sent;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0)
        set_delivery(!model_deliver);
      text_buf.delete();
      repeat ($urandom_range(1, 4)) add_line();
      if ($urandom_range(0, 1) == 0)
        void'(text_buf.pop_back());  // drop the final line end now and then
      foreach (text_buf[i])
        send_item(kvlp_pkg::KIND_BYTE, text_buf[i]);
      end_text();
    end
    steady = 1'b0;
  endtask

  initial begin : stimulus
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 1'b0;
    text_if.valid     = 1'b0;
    text_if.kind      = kvlp_pkg::KIND_BYTE;
    text_if.text_byte = 8'd0;
    model_deliver     = 1'b1;
    restart_parse();
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_empty_text();
    test_well_formed_pairs();
    test_syntax_errors();
    test_ws_overflow();
    test_without_delivery();
    test_random_texts();

    // Drain: every prediction must be met, then nothing more may arrive
    idle_input();
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0)
      $display("** key_value_line_parser: PASSED **");
    else
      $display("** key_value_line_parser: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #100_000_000;
    $display("** key_value_line_parser: FAILED **");
    $finish;
  end

endmodule
